// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_PROP(label, clk, rst_n, !(cond), msg)

`endif

// ===== rtl/nfc4_pkg.sv =====
package nfc4_pkg;

  localparam int unsigned MEM_DEPTH_DEF = 1024;
  localparam int unsigned FRAME_MAX_DEF = 256;
  localparam int unsigned RESP_MAX = 64;
  localparam int unsigned HEAD_N = 15;
  localparam int unsigned CC_LEN = 15;

  localparam logic [10:0] NDEF_SIZE_RST = 11'd1024;
  localparam logic [6:0] TX_CAP_RST = 7'd64;

  localparam logic [0:0] REG_NDEF_SIZE = 1'b0;
  localparam logic [0:0] REG_TX_CAP = 1'b1;

  localparam logic [15:0] FID_CC = 16'hE103;
  localparam logic [15:0] FID_NDEF = 16'hE104;
  localparam logic [15:0] MAX_LE = 16'h00F6;

  localparam logic [15:0] SW_OK = 16'h9000;
  localparam logic [15:0] SW_LEN = 16'h6700;
  localparam logic [15:0] SW_DENIED = 16'h6982;
  localparam logic [15:0] SW_NOFILE = 16'h6A82;
  localparam logic [15:0] SW_NOSPACE = 16'h6A84;
  localparam logic [15:0] SW_P1P2 = 16'h6A86;
  localparam logic [15:0] SW_INS = 16'h6D00;
  localparam logic [15:0] SW_CLA = 16'h6E00;

  localparam logic [7:0] PCB_ATS_REQ = 8'hE0;
  localparam logic [7:0] PCB_DESEL = 8'hC2;
  localparam logic [7:0] PCB_IMASK = 8'hE2;
  localparam logic [7:0] PCB_IBLK = 8'h02;
  localparam logic [7:0] CLA_ISO = 8'h00;
  localparam logic [7:0] INS_SELECT = 8'hA4;
  localparam logic [7:0] INS_READ = 8'hB0;
  localparam logic [7:0] INS_UPDATE = 8'hD6;
  localparam logic [7:0] P1_AID = 8'h04;
  localparam logic [7:0] P1_FID = 8'h00;

  localparam logic [7:0] ATS_B0 = 8'h03;
  localparam logic [7:0] ATS_B1 = 8'h28;
  localparam logic [7:0] ATS_B2 = 8'h80;

  localparam logic [1:0] FILE_NONE = 2'd0;
  localparam logic [1:0] FILE_CC = 2'd1;
  localparam logic [1:0] FILE_NDEF = 2'd2;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_out;
  } out_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_ATS,
    KIND_DESEL,
    KIND_IBLK
  } kind_e;

  typedef enum logic [3:0] {
    BSEL_ATS0,
    BSEL_ATS1,
    BSEL_ATS2,
    BSEL_DESEL,
    BSEL_HDR0,
    BSEL_HDR1,
    BSEL_DATA,
    BSEL_SW1,
    BSEL_SW2
  } bsel_e;

  typedef struct packed {
    logic  accept;
    logic  decode;
    logic  clip;
    logic  clr;
    logic  copy_rd;
    logic  copy_wr;
    logic  data_rd;
    logic  emit;
    bsel_e bsel;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  reply_ok;
    logic  cid;
    logic  copy_needed;
    logic  copy_done;
    logic  dlen_zero;
    logic  data_done;
    logic  clr_done;
  } stat_t;

  function automatic logic [7:0] aid_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'hD2;
      3'd1: b = 8'h76;
      3'd4: b = 8'h85;
      3'd5: b = 8'h01;
      3'd6: b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] cc_byte(input logic [3:0] idx, input logic [15:0] size);
    logic [7:0] b;
    case (idx)
      4'd1: b = 8'(CC_LEN);
      4'd2: b = 8'h20;
      4'd3: b = MAX_LE[15:8];
      4'd4: b = MAX_LE[7:0];
      4'd5: b = MAX_LE[15:8];
      4'd6: b = MAX_LE[7:0];
      4'd7: b = 8'h04;
      4'd8: b = 8'h06;
      4'd9: b = FID_NDEF[15:8];
      4'd10: b = FID_NDEF[7:0];
      4'd11: b = size[15:8];
      4'd12: b = size[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/nfc4_dp.sv =====
module nfc4_dp #(
  parameter int unsigned MemDepth = nfc4_pkg::MEM_DEPTH_DEF,
  parameter int unsigned FrameMax = nfc4_pkg::FRAME_MAX_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  nfc4_pkg::cmd_t  cmd_i,
  output nfc4_pkg::stat_t stat_o,
  input  nfc4_pkg::in_t   in_i,
  input  logic            cfg_valid_i,
  input  logic [0:0]      cfg_idx_i,
  input  logic [10:0]     cfg_data_i,
  output nfc4_pkg::out_t  out_o,
  output logic            out_strobe_o
);

  localparam int unsigned MemAw = $clog2(MemDepth);
  localparam int unsigned FrameAw = $clog2(FrameMax);
  localparam int unsigned FlenW = $clog2(FrameMax + 1);

  logic [10:0] ndef_size_q;
  logic [6:0] tx_cap_q;
  logic [FlenW-1:0] flen_q, flen_next, n_q;
  logic [7:0] head_q [nfc4_pkg::HEAD_N];
  logic [7:0] fbuf [FrameMax];
  logic [7:0] mem [MemDepth];
  logic [7:0] fbuf_rdata_q, mem_rdata_q, cc_q;
  logic sel_q, sel_d;
  logic [1:0] file_q, file_d;

  nfc4_pkg::kind_e kind_q, kind_d;
  logic ok_q, ok_d, cid_q, src_cc_q, src_cc_d, copy_q, copy_d;
  logic [15:0] sw_q, sw_d, doff_q;
  logic [8:0] lraw_q, lraw_d;
  logic [6:0] room_q, room_d, dlen_q;
  logic [7:0] lc_q, tx_pcb_q, cidb_q;
  logic [1:0] hdr_q;
  logic [7:0] k_q;
  logic [MemAw-1:0] clr_cnt_q;
  nfc4_pkg::out_t out_q;
  logic strobe_q;

  logic [7:0] pcb, lc;
  logic [7:0] a [12];
  logic [1:0] hdr, rhdr;
  logic [9:0] nw, m, lc10;
  logic [6:0] cap;
  logic [16:0] size17, off17, avail17, waddr17, raddr17;
  logic [15:0] off, fid;
  logic [8:0] le9, fsum;
  logic [3:0] cc_idx;
  logic aid_ok, m_lt5, m_lt_lc;

  always_comb begin
    pcb = head_q[0];
    hdr = 2'd1 + {1'b0, pcb[3]} + {1'b0, pcb[2]};
    rhdr = 2'd1 + {1'b0, pcb[3]};
    for (int i = 0; i < 12; i++) begin
      case (hdr)
        2'd2: a[i] = head_q[i + 2];
        2'd3: a[i] = head_q[i + 3];
        default: a[i] = head_q[i + 1];
      endcase
    end
    nw = 10'(n_q);
    m = nw - {8'b0, hdr};
    lc = a[4];
    lc10 = {2'b0, lc};
    m_lt5 = m < 10'd5;
    m_lt_lc = m < (10'd5 + lc10);
    cap = (tx_cap_q < 7'(nfc4_pkg::RESP_MAX)) ? tx_cap_q : 7'(nfc4_pkg::RESP_MAX);
    size17 = ({6'b0, ndef_size_q} < 17'(MemDepth)) ? {6'b0, ndef_size_q} : 17'(MemDepth);
    off = {a[2], a[3]};
    off17 = {1'b0, off};
    fid = {a[5], a[6]};
    le9 = (a[4] == 8'h00) ? 9'd256 : {1'b0, a[4]};
    aid_ok = (lc == 8'd7);
    for (int j = 0; j < 7; j++) begin
      if (a[j + 5] != nfc4_pkg::aid_byte(3'(j))) begin
        aid_ok = 1'b0;
      end
    end
    avail17 = 17'd0;

    kind_d = nfc4_pkg::KIND_NONE;
    ok_d = 1'b0;
    sw_d = nfc4_pkg::SW_OK;
    src_cc_d = 1'b0;
    lraw_d = 9'd0;
    copy_d = 1'b0;
    room_d = 7'd0;
    sel_d = sel_q;
    file_d = file_q;

    if (pcb == nfc4_pkg::PCB_ATS_REQ) begin
      kind_d = nfc4_pkg::KIND_ATS;
      ok_d = cap >= 7'd3;
      sel_d = 1'b0;
      file_d = nfc4_pkg::FILE_NONE;
    end else if (pcb == nfc4_pkg::PCB_DESEL) begin
      kind_d = nfc4_pkg::KIND_DESEL;
      ok_d = cap >= 7'd1;
      sel_d = 1'b0;
      file_d = nfc4_pkg::FILE_NONE;
    end else if (((pcb & nfc4_pkg::PCB_IMASK) == nfc4_pkg::PCB_IBLK) && (nw >= {8'b0, hdr})) begin
      kind_d = nfc4_pkg::KIND_IBLK;
      ok_d = cap >= ({5'b0, rhdr} + 7'd2);
      room_d = cap - {5'b0, rhdr} - 7'd2;
      if (m < 10'd4) begin
        sw_d = nfc4_pkg::SW_LEN;
      end else if (a[0] != nfc4_pkg::CLA_ISO) begin
        sw_d = nfc4_pkg::SW_CLA;
      end else begin
        case (a[1])
          nfc4_pkg::INS_SELECT: begin
            if (m_lt5 || m_lt_lc) begin
              sw_d = nfc4_pkg::SW_LEN;
            end else if (a[2] == nfc4_pkg::P1_AID) begin
              if (aid_ok) begin
                sel_d = 1'b1;
                file_d = nfc4_pkg::FILE_NONE;
              end else begin
                sw_d = nfc4_pkg::SW_NOFILE;
              end
            end else if (a[2] == nfc4_pkg::P1_FID) begin
              if (lc != 8'd2) begin
                sw_d = nfc4_pkg::SW_LEN;
              end else if (sel_q && (fid == nfc4_pkg::FID_CC || fid == nfc4_pkg::FID_NDEF)) begin
                file_d = (fid == nfc4_pkg::FID_CC) ? nfc4_pkg::FILE_CC : nfc4_pkg::FILE_NDEF;
              end else begin
                sw_d = nfc4_pkg::SW_NOFILE;
              end
            end else begin
              sw_d = nfc4_pkg::SW_P1P2;
            end
          end
          nfc4_pkg::INS_READ: begin
            if (m_lt5) begin
              sw_d = nfc4_pkg::SW_LEN;
            end else if (sel_q && file_q == nfc4_pkg::FILE_CC) begin
              if (off >= 16'(nfc4_pkg::CC_LEN)) begin
                sw_d = nfc4_pkg::SW_P1P2;
              end else begin
                src_cc_d = 1'b1;
                avail17 = 17'(nfc4_pkg::CC_LEN) - off17;
                lraw_d = (avail17 < {8'b0, le9}) ? avail17[8:0] : le9;
              end
            end else if (sel_q && file_q == nfc4_pkg::FILE_NDEF) begin
              if (off17 >= size17) begin
                sw_d = nfc4_pkg::SW_P1P2;
              end else begin
                avail17 = size17 - off17;
                lraw_d = (avail17 < {8'b0, le9}) ? avail17[8:0] : le9;
              end
            end else begin
              sw_d = nfc4_pkg::SW_NOFILE;
            end
          end
          nfc4_pkg::INS_UPDATE: begin
            if (m_lt5) begin
              sw_d = nfc4_pkg::SW_LEN;
            end else if (!(sel_q && file_q == nfc4_pkg::FILE_NDEF)) begin
              sw_d = nfc4_pkg::SW_DENIED;
            end else if (m_lt_lc || lc > nfc4_pkg::MAX_LE[7:0]) begin
              sw_d = nfc4_pkg::SW_LEN;
            end else if ((off17 + {9'b0, lc}) > size17) begin
              sw_d = nfc4_pkg::SW_NOSPACE;
            end else begin
              copy_d = 1'b1;
            end
          end
          default: sw_d = nfc4_pkg::SW_INS;
        endcase
      end
      // Without room beyond the reply header the command is not run at all.
      if (cap <= {5'b0, rhdr}) begin
        sel_d = sel_q;
        file_d = file_q;
        copy_d = 1'b0;
      end
    end
  end

  assign flen_next = (flen_q < FlenW'(FrameMax)) ? flen_q + 1'b1 : flen_q;
  assign fsum = {7'b0, hdr_q} + 9'd5 + {1'b0, k_q};
  assign waddr17 = {1'b0, doff_q} + {9'b0, k_q};
  assign raddr17 = waddr17;
  assign cc_idx = raddr17[3:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ndef_size_q <= nfc4_pkg::NDEF_SIZE_RST;
      tx_cap_q <= nfc4_pkg::TX_CAP_RST;
      flen_q <= '0;
      n_q <= '0;
      sel_q <= 1'b0;
      file_q <= nfc4_pkg::FILE_NONE;
      kind_q <= nfc4_pkg::KIND_NONE;
      ok_q <= 1'b0;
      copy_q <= 1'b0;
      k_q <= 8'd0;
      clr_cnt_q <= '0;
      strobe_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_idx_i)
          nfc4_pkg::REG_NDEF_SIZE: ndef_size_q <= cfg_data_i;
          nfc4_pkg::REG_TX_CAP: tx_cap_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        if (in_i.last_byte) begin
          flen_q <= '0;
          n_q <= flen_next;
        end else begin
          flen_q <= flen_next;
        end
      end
      if (cmd_i.decode) begin
        sel_q <= sel_d;
        file_q <= file_d;
        kind_q <= kind_d;
        ok_q <= ok_d;
        copy_q <= copy_d;
      end
      if (cmd_i.clip) begin
        k_q <= 8'd0;
      end else if (cmd_i.copy_wr || cmd_i.data_rd) begin
        k_q <= k_q + 8'd1;
      end
      if (cmd_i.clr) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      strobe_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      if (flen_q < FlenW'(FrameMax)) begin
        fbuf[flen_q[FrameAw-1:0]] <= in_i.rx_byte;
      end
      if (flen_q < FlenW'(nfc4_pkg::HEAD_N)) begin
        head_q[flen_q[3:0]] <= in_i.rx_byte;
      end
    end
    if (cmd_i.decode) begin
      sw_q <= sw_d;
      src_cc_q <= src_cc_d;
      lraw_q <= lraw_d;
      room_q <= room_d;
      doff_q <= off;
      lc_q <= lc;
      hdr_q <= hdr;
      cid_q <= pcb[3];
      cidb_q <= head_q[1];
      tx_pcb_q <= nfc4_pkg::PCB_IBLK | {7'b0, pcb[0]} | {4'b0, pcb[3], 3'b0};
    end
    if (cmd_i.clip) begin
      dlen_q <= ({2'b0, room_q} < lraw_q) ? room_q : lraw_q[6:0];
    end
    if (cmd_i.copy_rd) begin
      fbuf_rdata_q <= fbuf[fsum[FrameAw-1:0]];
    end
    if (cmd_i.clr) begin
      mem[clr_cnt_q] <= 8'h00;
    end else if (cmd_i.copy_wr) begin
      mem[waddr17[MemAw-1:0]] <= fbuf_rdata_q;
    end
    if (cmd_i.data_rd) begin
      mem_rdata_q <= mem[raddr17[MemAw-1:0]];
      cc_q <= nfc4_pkg::cc_byte(cc_idx, size17[15:0]);
    end
    if (cmd_i.emit) begin
      out_q.last_out <= (cmd_i.bsel == nfc4_pkg::BSEL_SW2) ||
                        (cmd_i.bsel == nfc4_pkg::BSEL_ATS2) ||
                        (cmd_i.bsel == nfc4_pkg::BSEL_DESEL);
      case (cmd_i.bsel)
        nfc4_pkg::BSEL_ATS0: out_q.tx_byte <= nfc4_pkg::ATS_B0;
        nfc4_pkg::BSEL_ATS1: out_q.tx_byte <= nfc4_pkg::ATS_B1;
        nfc4_pkg::BSEL_ATS2: out_q.tx_byte <= nfc4_pkg::ATS_B2;
        nfc4_pkg::BSEL_DESEL: out_q.tx_byte <= nfc4_pkg::PCB_DESEL;
        nfc4_pkg::BSEL_HDR0: out_q.tx_byte <= tx_pcb_q;
        nfc4_pkg::BSEL_HDR1: out_q.tx_byte <= cidb_q;
        nfc4_pkg::BSEL_DATA: out_q.tx_byte <= src_cc_q ? cc_q : mem_rdata_q;
        nfc4_pkg::BSEL_SW1: out_q.tx_byte <= sw_q[15:8];
        default: out_q.tx_byte <= sw_q[7:0];
      endcase
    end
  end

  always_comb begin
    stat_o.kind = kind_q;
    stat_o.reply_ok = ok_q;
    stat_o.cid = cid_q;
    stat_o.copy_needed = copy_q && (lc_q != 8'd0);
    stat_o.copy_done = (k_q == lc_q);
    stat_o.dlen_zero = (dlen_q == 7'd0);
    stat_o.data_done = ({1'b0, dlen_q} == k_q);
    stat_o.clr_done = (clr_cnt_q == MemAw'(MemDepth - 1));
  end

  assign out_o = out_q;
  assign out_strobe_o = strobe_q;

endmodule

// ===== rtl/nfc4_ctrl.sv =====
module nfc4_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic            last_i,
  output logic            busy,
  output nfc4_pkg::cmd_t  cmd_o,
  input  nfc4_pkg::stat_t stat_i
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_CLIP,
    S_COPY_RD,
    S_COPY_WR,
    S_ATS0,
    S_ATS1,
    S_ATS2,
    S_DESEL,
    S_HDR0,
    S_HDR1,
    S_DRD,
    S_DOUT,
    S_SW1,
    S_SW2
  } state_e;

  state_e state_q, state_d, reply_st, data_st;
  logic busy_q;

  always_comb begin
    reply_st = S_IDLE;
    if (stat_i.reply_ok) begin
      unique case (stat_i.kind)
        nfc4_pkg::KIND_ATS: reply_st = S_ATS0;
        nfc4_pkg::KIND_DESEL: reply_st = S_DESEL;
        nfc4_pkg::KIND_IBLK: reply_st = S_HDR0;
        default: reply_st = S_IDLE;
      endcase
    end
    data_st = stat_i.dlen_zero ? S_SW1 : S_DRD;
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (stat_i.clr_done) state_d = S_IDLE;
      S_IDLE: if (start && last_i) state_d = S_DECODE;
      S_DECODE: state_d = S_CLIP;
      S_CLIP: begin
        if (stat_i.kind == nfc4_pkg::KIND_IBLK && stat_i.copy_needed) begin
          state_d = S_COPY_RD;
        end else begin
          state_d = reply_st;
        end
      end
      S_COPY_RD: state_d = stat_i.copy_done ? reply_st : S_COPY_WR;
      S_COPY_WR: state_d = S_COPY_RD;
      S_ATS0: state_d = S_ATS1;
      S_ATS1: state_d = S_ATS2;
      S_ATS2: state_d = S_IDLE;
      S_DESEL: state_d = S_IDLE;
      S_HDR0: state_d = stat_i.cid ? S_HDR1 : data_st;
      S_HDR1: state_d = data_st;
      S_DRD: state_d = S_DOUT;
      S_DOUT: state_d = stat_i.data_done ? S_SW1 : S_DRD;
      S_SW1: state_d = S_SW2;
      S_SW2: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      busy_q <= 1'b1;
    end else begin
      state_q <= state_d;
      busy_q <= (state_d != S_IDLE);
    end
  end

  always_comb begin
    cmd_o.accept = (state_q == S_IDLE) && start;
    cmd_o.decode = (state_q == S_DECODE);
    cmd_o.clip = (state_q == S_CLIP);
    cmd_o.clr = (state_q == S_CLEAR);
    cmd_o.copy_rd = (state_q == S_COPY_RD) && !stat_i.copy_done;
    cmd_o.copy_wr = (state_q == S_COPY_WR);
    cmd_o.data_rd = (state_q == S_DRD);
    cmd_o.emit = 1'b1;
    cmd_o.bsel = nfc4_pkg::BSEL_SW2;
    unique case (state_q)
      S_ATS0: cmd_o.bsel = nfc4_pkg::BSEL_ATS0;
      S_ATS1: cmd_o.bsel = nfc4_pkg::BSEL_ATS1;
      S_ATS2: cmd_o.bsel = nfc4_pkg::BSEL_ATS2;
      S_DESEL: cmd_o.bsel = nfc4_pkg::BSEL_DESEL;
      S_HDR0: cmd_o.bsel = nfc4_pkg::BSEL_HDR0;
      S_HDR1: cmd_o.bsel = nfc4_pkg::BSEL_HDR1;
      S_DOUT: cmd_o.bsel = nfc4_pkg::BSEL_DATA;
      S_SW1: cmd_o.bsel = nfc4_pkg::BSEL_SW1;
      S_SW2: cmd_o.bsel = nfc4_pkg::BSEL_SW2;
      default: cmd_o.emit = 1'b0;
    endcase
  end

  assign busy = busy_q;

endmodule

// ===== rtl/nfc_type4_tag_frame_responder_top.sv =====
// Type 4 tag frame responder. Reader frame bytes enter on in_i, one transfer
// per cycle in which start is high and busy is low; last_byte closes a frame.
// Bytes of a frame are taken back to back, one per cycle.
// After the last byte, busy stays high while the frame is handled: the DECODE
// and CLIP states, COPY_RD and COPY_WR per UPDATE BINARY byte, then the reply.
// Reply bytes appear on out_o, each for one cycle with out_strobe_o high;
// header, fixed and status bytes are each shown from a single state, and read
// data bytes pass through S_DRD then S_DOUT, as the NDEF memory read is registered.
// A frame without a reply frees the block after DECODE, CLIP and any copy.
// The receiver cannot stall; every strobed byte is taken as it is shown.
// Configuration writes use cfg_valid_i with cfg_ready_o, which is always high,
// and must only be issued while busy is low.
// After reset the NDEF memory is cleared one byte per cycle, so busy stays
// high until all MemDepth bytes are cleared, before the first frame is accepted.
module nfc_type4_tag_frame_responder_top #(
  parameter int unsigned MemDepth = nfc4_pkg::MEM_DEPTH_DEF,
  parameter int unsigned FrameMax = nfc4_pkg::FRAME_MAX_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  nfc4_pkg::in_t  in_i,
  output logic           out_strobe_o,
  output nfc4_pkg::out_t out_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [0:0]     cfg_idx_i,
  input  logic [10:0]    cfg_data_i
);

  nfc4_pkg::cmd_t cmd;
  nfc4_pkg::stat_t stat;

  nfc4_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .last_i (in_i.last_byte),
    .busy   (busy),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  nfc4_dp #(
    .MemDepth (MemDepth),
    .FrameMax (FrameMax)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_i         (in_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .out_o        (out_o),
    .out_strobe_o (out_strobe_o)
  );

  assign cfg_ready_o = 1'b1;

endmodule

// ===== rtl/nfc4_chk.sv =====
`include "assert_macros.svh"

module nfc4_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input nfc4_pkg::in_t  in_i,
  input logic           out_strobe_o,
  input nfc4_pkg::out_t out_o
);

  `ASSERT_PROP(a_mid_byte_busy, clk_i, rst_ni, out_strobe_o && !out_o.last_out |-> busy, "reply byte shown while idle")
  `ASSERT_PROP(a_accept_no_strobe, clk_i, rst_ni, start && !busy |=> !out_strobe_o, "reply byte right after an input transfer")
  `ASSERT_PROP(a_last_goes_busy, clk_i, rst_ni, start && !busy && in_i.last_byte |=> busy, "frame end did not start processing")
  `ASSERT_PROP(a_last_ends_reply, clk_i, rst_ni, out_strobe_o && out_o.last_out |=> !out_strobe_o, "reply byte after the final byte")

endmodule

bind nfc_type4_tag_frame_responder_top nfc4_chk u_chk (.*);
